>>> rtl/core/srdp_pkg.sv
package srdp_pkg;

    // Block sizing and fixed-point format.
    localparam int ROW_DEPTH  = 64;
    localparam int FRAC_BITS  = 16;
    localparam int ROW_LEN    = 6;
    localparam int ELEM_W     = 32;
    localparam int IDX_W      = 6;
    localparam int ROWS_W     = 7;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Datapath widths: a product, a pair of products, the six-term sum,
    // the sum with the rounding bias, the clamped dot product and the
    // combined value before saturation.
    localparam int PROD_W = 2 * ELEM_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;
    localparam int RND_W  = SUM_W + 1;
    localparam int DOT_W  = ELEM_W + 2;
    localparam int CMB_W  = ELEM_W + 3;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_SET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STORED_ROWS  = 1'b1;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] row_index;
        elem_t            elem0;
        elem_t            elem1;
        elem_t            elem2;
        elem_t            elem4;
        elem_t            elem5;
        elem_t            elem6;
        elem_t            old_value;
        logic             last_item;
    } item_t;

    typedef struct packed {
        elem_t value;
        logic  last;
        logic  bad_index;
    } result_t;

    // Per-lane controls for the row store and the multiplier.
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             prod_en;
        logic [IDX_W-1:0] addr;
    } lane_ctrl_t;

    // Fields that ride alongside the products through the merge pipeline.
    typedef struct packed {
        elem_t old_value;
        logic  bad;
        logic  last;
    } side_t;

endpackage

>>> rtl/core/srdp_ram.sv
module srdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/srdp_lane.sv
module srdp_lane (
    input  logic                   clk,
    input  srdp_pkg::lane_ctrl_t   ctrl,
    input  srdp_pkg::elem_t        elem,
    output srdp_pkg::prod_t        prod
);

    import srdp_pkg::*;

    logic [ELEM_W-1:0] c_word;
    elem_t             c_elem;
    elem_t             b_reg;
    prod_t             prod_reg;

    // This lane's column of the row store; one element of every stored row.
    srdp_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (ROW_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .waddr (ctrl.addr),
        .wdata (elem),
        .re    (ctrl.rd_en),
        .raddr (ctrl.addr),
        .rdata (c_word)
    );

    assign c_elem = elem_t'(c_word);

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            b_reg <= elem;
        end
        if (ctrl.prod_en)
        begin
            prod_reg <= b_reg * c_elem;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/srdp_merge.sv
module srdp_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [srdp_pkg::MODE_W-1:0] mode,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  srdp_pkg::side_t           side,
    input  srdp_pkg::prod_t           prods [srdp_pkg::ROW_LEN],
    output logic                      out_valid,
    input  logic                      out_ready,
    output srdp_pkg::result_t         out_data
);

    import srdp_pkg::*;

    localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(2 ** FRAC_BITS / 2);
    localparam logic signed [RND_W-1:0] DOT_MAX    = RND_W'(64'sd4294967296);
    localparam logic signed [RND_W-1:0] DOT_MIN    = -DOT_MAX;
    localparam logic signed [CMB_W-1:0] SAT_MAX    = CMB_W'(64'sd2147483647);
    localparam logic signed [CMB_W-1:0] SAT_MIN    = CMB_W'(-64'sd2147483648);

    logic v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic free2, free3, free4, free5, free_o;

    side_t side2_reg, side3_reg, side4_reg, side5_reg;

    logic signed [PAIR_W-1:0] pair_reg [3];
    logic signed [SUM_W-1:0]  total_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    result_t                  out_reg;

    logic signed [SUM_W-1:0]  total_next;
    logic signed [RND_W-1:0]  rounded;
    logic signed [RND_W-1:0]  shifted;
    logic signed [DOT_W-1:0]  dot_next;
    logic signed [CMB_W-1:0]  old_ext;
    logic signed [CMB_W-1:0]  dot_ext;
    logic signed [CMB_W-1:0]  comb;
    elem_t                    value_next;

    // Each stage moves on when the stage after it is empty or moving on too.
    assign free_o   = !vo_reg || out_ready;
    assign free5    = !v5_reg || free_o;
    assign free4    = !v4_reg || free5;
    assign free3    = !v3_reg || free4;
    assign free2    = !v2_reg || free3;
    assign in_ready = free2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (free2)
            begin
                v2_reg <= in_valid;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (free4)
            begin
                v4_reg <= v3_reg;
            end
            if (free5)
            begin
                v5_reg <= v4_reg;
            end
            if (free_o)
            begin
                vo_reg <= v5_reg;
            end
        end
    end

    assign total_next = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]) + SUM_W'(pair_reg[2]);

    // Round to nearest with ties upward, then clamp to a range wide enough
    // that the final saturation comes out the same.
    assign rounded = RND_W'(total_reg) + ROUND_BIAS;
    assign shifted = rounded >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > DOT_MAX)
        begin
            dot_next = DOT_W'(DOT_MAX);
        end
        else if (shifted < DOT_MIN)
        begin
            dot_next = DOT_W'(DOT_MIN);
        end
        else
        begin
            dot_next = DOT_W'(shifted);
        end
    end

    assign old_ext = CMB_W'(side5_reg.old_value);
    assign dot_ext = CMB_W'(dot_reg);

    always_comb
    begin
        unique case (mode)
            MODE_ADD: comb = old_ext + dot_ext;
            MODE_SUB: comb = old_ext - dot_ext;
            default:  comb = dot_ext;
        endcase
    end

    always_comb
    begin
        if (side5_reg.bad)
        begin
            value_next = '0;
        end
        else if (comb > SAT_MAX)
        begin
            value_next = ELEM_W'(SAT_MAX);
        end
        else if (comb < SAT_MIN)
        begin
            value_next = ELEM_W'(SAT_MIN);
        end
        else
        begin
            value_next = ELEM_W'(comb);
        end
    end

    always_ff @(posedge clk)
    begin
        if (free2)
        begin
            side2_reg <= side;
        end
        if (free3)
        begin
            side3_reg   <= side2_reg;
            pair_reg[0] <= PAIR_W'(prods[0]) + PAIR_W'(prods[1]);
            pair_reg[1] <= PAIR_W'(prods[2]) + PAIR_W'(prods[3]);
            pair_reg[2] <= PAIR_W'(prods[4]) + PAIR_W'(prods[5]);
        end
        if (free4)
        begin
            side4_reg <= side3_reg;
            total_reg <= total_next;
        end
        if (free5)
        begin
            side5_reg <= side4_reg;
            dot_reg   <= dot_next;
        end
        if (free_o)
        begin
            out_reg.value     <= value_next;
            out_reg.last      <= side5_reg.last;
            out_reg.bad_index <= side5_reg.bad;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/core/sparse_row_dot_product.sv
// Sparse row dot product. Load transfers (kind 0) write six Q16.16 elements
// into the row store at row_index and produce no result. Compute transfers
// (kind 1) multiply their six elements with the stored row at row_index in six
// parallel lanes, sum the products exactly, round to nearest (ties upward),
// then set, add to or subtract from old_value by combine_mode and saturate to
// 32 bits. An index not below stored_rows gives value zero with bad_index set.
// The block takes one transfer per clock while result_ready does not stall
// it; a result is registered through the row store read (loaded at the edge
// that accepts its compute transfer), the multiplier register and four merge
// stages (pair sums, total, rounding, combine). Each lane's column
// of the row store is an undefined-at-reset RAM: only rows that were loaded
// may be read. Configuration writes complete at once and must be made while
// no compute transfer is in flight.
module sparse_row_dot_product (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  srdp_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output srdp_pkg::result_t                result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srdp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import srdp_pkg::*;

    localparam logic [ROWS_W-1:0] DEPTH_LIMIT = ROWS_W'(ROW_DEPTH);

    logic [MODE_W-1:0] mode_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [ROWS_W-1:0] limit;

    logic       s1_valid_reg;
    side_t      s1_side_reg;
    side_t      side_next;
    logic       accept;
    logic       merge_ready;
    lane_ctrl_t ctrl;
    elem_t      elems [ROW_LEN];
    prod_t      prods [ROW_LEN];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SET;
            rows_reg <= DEPTH_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COMBINE_MODE: mode_reg <= cfg_data[MODE_W-1:0];
                REG_STORED_ROWS:  rows_reg <= cfg_data;
            endcase
        end
    end

    assign limit = (rows_reg > DEPTH_LIMIT) ? DEPTH_LIMIT : rows_reg;

    assign item_ready = !s1_valid_reg || merge_ready;
    assign accept     = item_valid && item_ready;

    assign side_next.old_value = item.old_value;
    assign side_next.bad       = ROWS_W'(item.row_index) >= limit;
    assign side_next.last      = item.last_item;

    assign ctrl.wr_en   = accept && (item.kind == KIND_LOAD);
    assign ctrl.rd_en   = accept && (item.kind == KIND_COMPUTE);
    assign ctrl.prod_en = merge_ready;
    assign ctrl.addr    = item.row_index;

    // Stage 1 holds a compute transfer while its stored row is read out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= ctrl.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_side_reg <= side_next;
        end
    end

    assign elems[0] = item.elem0;
    assign elems[1] = item.elem1;
    assign elems[2] = item.elem2;
    assign elems[3] = item.elem4;
    assign elems[4] = item.elem5;
    assign elems[5] = item.elem6;

    for (genvar g = 0; g < ROW_LEN; g++)
    begin : g_lane
        srdp_lane u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .elem (elems[g]),
            .prod (prods[g])
        );
    end

    srdp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .in_valid  (s1_valid_reg),
        .in_ready  (merge_ready),
        .side      (s1_side_reg),
        .prods     (prods),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (result)
    );

    // A flagged index always comes out as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bad_index |-> result.value == '0)
    else $error("bad index result carries a nonzero value");

    // Load transfers never occupy the compute pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.kind == KIND_LOAD |=> !s1_valid_reg)
    else $error("load transfer entered the compute pipeline");

    // A compute transfer stalled in stage 1 keeps its side fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !merge_ready |=> s1_valid_reg && $stable(s1_side_reg))
    else $error("stage 1 lost or changed a stalled transfer");

endmodule
